// ----- design/cfe_pkg.sv -----
// ----------------------------------------------------------------------------
// Conditional force effect package
// Field widths, effect kind codes, register indexes and the register bank type
// shared by the force effect core and its datapath.
// ----------------------------------------------------------------------------
package cfe_pkg;

    localparam int FUNC_W     = 2;
    localparam int AXIS_W     = 16;
    localparam int BAND_W     = 15;
    localparam int COEF_W     = 16;
    localparam int SAT_W      = 15;
    localparam int FORCE_W    = 19;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // band edges and distances past them
    localparam int EXT_W      = AXIS_W + 2;
    // coefficient operand, wide enough for a negated coefficient
    localparam int MUL_B_W    = COEF_W + 1;
    localparam int PROD_W     = EXT_W + MUL_B_W;

    localparam int COEF_FRAC_BITS = 14;
    localparam int FRICTION_RAMP_SHIFT_DEFAULT = 8;

    // effect kinds
    localparam logic [FUNC_W-1:0] FUNC_SPRING   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DAMPER   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INERTIA  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FRICTION = 2'd3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_CENTRE_OFFSET = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEAD_BAND     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_POS_COEF      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_NEG_COEF      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_POS_SAT       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_NEG_SAT       = 3'd5;

    typedef struct packed {
        logic [AXIS_W-1:0] centre_offset;
        logic [BAND_W-1:0] dead_band;
        logic [COEF_W-1:0] positive_coefficient;
        logic [COEF_W-1:0] negative_coefficient;
        logic [SAT_W-1:0]  positive_saturation;
        logic [SAT_W-1:0]  negative_saturation;
    } cfg_t;

endpackage

// ----- design/cfe_force_calc.sv -----
// ----------------------------------------------------------------------------
// Conditional force effect datapath
// Dead band, one shared signed multiply, fixed-point shift and clamping for
// spring, damper, inertia and friction.
// ----------------------------------------------------------------------------
module cfe_force_calc #(
    parameter int FRICTION_RAMP_SHIFT = cfe_pkg::FRICTION_RAMP_SHIFT_DEFAULT
) (
    input  logic [cfe_pkg::FUNC_W-1:0]         func,
    input  logic signed [cfe_pkg::AXIS_W-1:0]  axis_position,
    input  logic signed [cfe_pkg::AXIS_W-1:0]  axis_velocity,
    input  logic signed [cfe_pkg::AXIS_W-1:0]  axis_acceleration,
    input  cfe_pkg::cfg_t                      cfg,
    output logic signed [cfe_pkg::FORCE_W-1:0] force_res
);

    localparam int AW = cfe_pkg::AXIS_W;
    localparam int EW = cfe_pkg::EXT_W;
    localparam int BW = cfe_pkg::MUL_B_W;
    localparam int PW = cfe_pkg::PROD_W;

    localparam logic signed [EW-1:0] RAMP_LIMIT = EW'(1) << FRICTION_RAMP_SHIFT;
    localparam logic signed [PW-1:0] FORCE_MAX  = PW'((1 << (cfe_pkg::FORCE_W - 1)) - 1);
    localparam logic signed [PW-1:0] FORCE_MIN  = ~FORCE_MAX;

    logic signed [AW-1:0] value_sel;
    logic signed [EW-1:0] value_ext;
    logic signed [EW-1:0] centre_ext;
    logic signed [EW-1:0] band_ext;
    logic signed [EW-1:0] edge_lo;
    logic signed [EW-1:0] edge_hi;
    logic                 below;
    logic                 above;
    logic signed [EW-1:0] band_diff;
    logic signed [BW-1:0] pos_coef_ext;
    logic signed [BW-1:0] neg_coef_ext;
    logic signed [BW-1:0] band_coef;

    logic                 is_fric;
    logic                 is_inertia;
    logic                 vel_neg;
    logic                 vel_zero;
    logic signed [BW-1:0] vel_ext;
    logic signed [BW-1:0] vel_mag;
    logic signed [EW-1:0] excess;
    logic signed [BW-1:0] fric_coef;

    logic signed [EW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] product;
    logic signed [PW-1:0] q_band;
    logic signed [PW-1:0] q_fric;

    logic [cfe_pkg::SAT_W-1:0] sat_sel;
    logic signed [PW-1:0]      sat_ext;
    logic                      no_clamp;
    logic                      band_zero;
    logic signed [PW-1:0]      band_force;
    logic signed [PW-1:0]      fric_force;
    logic signed [PW-1:0]      force_raw;
    logic signed [PW-1:0]      force_lim;

    assign is_fric    = (func == cfe_pkg::FUNC_FRICTION);
    assign is_inertia = (func == cfe_pkg::FUNC_INERTIA);

    always_comb begin
        unique case (func)
            cfe_pkg::FUNC_SPRING:  value_sel = axis_position >>> 1;
            cfe_pkg::FUNC_DAMPER:  value_sel = axis_velocity;
            default:               value_sel = axis_acceleration;
        endcase
    end

    // dead band edges
    assign value_ext  = {{(EW - AW){value_sel[AW-1]}}, value_sel};
    assign centre_ext = {{(EW - AW){cfg.centre_offset[AW-1]}}, cfg.centre_offset};
    assign band_ext   = $signed({{(EW - cfe_pkg::BAND_W){1'b0}}, cfg.dead_band});
    assign edge_lo    = centre_ext - band_ext;
    assign edge_hi    = centre_ext + band_ext;
    assign below      = (value_ext < edge_lo);
    assign above      = (value_ext > edge_hi);
    assign band_diff  = below ? (value_ext - edge_lo) : (value_ext - edge_hi);

    assign pos_coef_ext = {cfg.positive_coefficient[cfe_pkg::COEF_W-1],
                           cfg.positive_coefficient};
    assign neg_coef_ext = {cfg.negative_coefficient[cfe_pkg::COEF_W-1],
                           cfg.negative_coefficient};
    assign band_coef    = below ? neg_coef_ext : pos_coef_ext;

    // friction: distance of |velocity| past the band, signed peak
    assign vel_neg   = axis_velocity[AW-1];
    assign vel_zero  = (axis_velocity == '0);
    assign vel_ext   = {axis_velocity[AW-1], axis_velocity};
    assign vel_mag   = vel_neg ? -vel_ext : vel_ext;
    assign excess    = {vel_mag[BW-1], vel_mag} - band_ext;
    assign fric_coef = vel_neg ? -neg_coef_ext : pos_coef_ext;

    // one multiplier serves both paths
    assign mul_a   = is_fric ? excess : band_diff;
    assign mul_b   = is_fric ? fric_coef : band_coef;
    assign product = mul_a * mul_b;
    assign q_band  = product >>> cfe_pkg::COEF_FRAC_BITS;
    assign q_fric  = product >>> FRICTION_RAMP_SHIFT;

    assign sat_sel   = below ? cfg.negative_saturation : cfg.positive_saturation;
    assign sat_ext   = $signed({{(PW - cfe_pkg::SAT_W){1'b0}}, sat_sel});
    // inertia treats a zero saturation as unlimited
    assign no_clamp  = is_inertia && (sat_sel == '0);
    // inertia pushes back only while decelerating
    assign band_zero = !(below || above) ||
                       (is_inertia && (axis_acceleration[AW-1] == vel_neg));

    always_comb begin
        priority if (band_zero) begin
            band_force = '0;
        end else if (!no_clamp && (q_band > sat_ext)) begin
            band_force = sat_ext;
        end else if (!no_clamp && (q_band < -sat_ext)) begin
            band_force = -sat_ext;
        end else begin
            band_force = q_band;
        end
    end

    always_comb begin
        priority if (vel_zero) begin
            fric_force = '0;
        end else if (excess > RAMP_LIMIT) begin
            fric_force = {{(PW - BW){fric_coef[BW-1]}}, fric_coef};
        end else if (excess > $signed(EW'(0))) begin
            fric_force = q_fric;
        end else begin
            fric_force = '0;
        end
    end

    assign force_raw = is_fric ? fric_force : band_force;

    always_comb begin
        priority if (force_raw > FORCE_MAX) begin
            force_lim = FORCE_MAX;
        end else if (force_raw < FORCE_MIN) begin
            force_lim = FORCE_MIN;
        end else begin
            force_lim = force_raw;
        end
    end

    assign force_res = force_lim[cfe_pkg::FORCE_W-1:0];

endmodule

// ----- design/conditional_force_effect_core.sv -----
// ----------------------------------------------------------------------------
// Conditional force effect core
// Evaluates spring, damper, inertia or friction force for one axis sample.
// ----------------------------------------------------------------------------
// The core takes one axis sample per clock while m_ready stays high and
// presents each force on m_valid from the result register: the sample is
// captured in an input register, passes the dead band, a single 18x17 signed
// multiply and the clamp logic, and lands in the result register. Throughput
// is one transaction per cycle as long as m_ready stays high; a stalled result
// holds in the result register while the input register still takes one more
// sample. Registers are written through cfg_we/cfg_addr/cfg_wdata, all reset
// to zero, and are expected to change only while no transaction is in flight.
module conditional_force_effect_core #(
    parameter int FRICTION_RAMP_SHIFT = cfe_pkg::FRICTION_RAMP_SHIFT_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_we,
    input  logic [cfe_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [cfe_pkg::CFG_DATA_W-1:0]        cfg_wdata,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [cfe_pkg::FUNC_W-1:0]            s_func,
    input  logic signed [cfe_pkg::AXIS_W-1:0]     s_axis_position,
    input  logic signed [cfe_pkg::AXIS_W-1:0]     s_axis_velocity,
    input  logic signed [cfe_pkg::AXIS_W-1:0]     s_axis_acceleration,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [cfe_pkg::FORCE_W-1:0]    m_force_res
);

    cfe_pkg::cfg_t cfg_reg;

    logic                               in_valid_reg;
    logic [cfe_pkg::FUNC_W-1:0]         func_reg;
    logic signed [cfe_pkg::AXIS_W-1:0]  position_reg;
    logic signed [cfe_pkg::AXIS_W-1:0]  velocity_reg;
    logic signed [cfe_pkg::AXIS_W-1:0]  accel_reg;

    logic                               out_valid_reg;
    logic signed [cfe_pkg::FORCE_W-1:0] force_reg;
    logic signed [cfe_pkg::FORCE_W-1:0] force_next;

    logic out_free;
    logic in_take;
    logic in_move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                cfe_pkg::REG_CENTRE_OFFSET: cfg_reg.centre_offset        <= cfg_wdata;
                cfe_pkg::REG_DEAD_BAND:
                    cfg_reg.dead_band <= cfg_wdata[cfe_pkg::BAND_W-1:0];
                cfe_pkg::REG_POS_COEF:      cfg_reg.positive_coefficient <= cfg_wdata;
                cfe_pkg::REG_NEG_COEF:      cfg_reg.negative_coefficient <= cfg_wdata;
                cfe_pkg::REG_POS_SAT:
                    cfg_reg.positive_saturation <= cfg_wdata[cfe_pkg::SAT_W-1:0];
                cfe_pkg::REG_NEG_SAT:
                    cfg_reg.negative_saturation <= cfg_wdata[cfe_pkg::SAT_W-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_ready;
    assign in_move  = in_valid_reg && out_free;
    assign s_ready  = aresetn && (!in_valid_reg || out_free);
    assign in_take  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (in_move) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            func_reg     <= s_func;
            position_reg <= s_axis_position;
            velocity_reg <= s_axis_velocity;
            accel_reg    <= s_axis_acceleration;
        end
    end

    cfe_force_calc #(
        .FRICTION_RAMP_SHIFT (FRICTION_RAMP_SHIFT)
    ) u_calc (
        .func              (func_reg),
        .axis_position     (position_reg),
        .axis_velocity     (velocity_reg),
        .axis_acceleration (accel_reg),
        .cfg               (cfg_reg),
        .force_res         (force_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // hold the result while the downstream side stalls
    always_ff @(posedge aclk) begin
        if (in_move) begin
            force_reg <= force_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_force_res = force_reg;

endmodule

// ----- design/cfe_checker.sv -----
// ----------------------------------------------------------------------------
// Conditional force effect port checker
// Watches the handshakes of the core and flags flow-control slips.
// ----------------------------------------------------------------------------
module cfe_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [cfe_pkg::FORCE_W-1:0]  m_force_res
);

    // a stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_force_res))
        else $error("stalled result changed or dropped");

    // reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // backpressure on the input only when both registers are occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while result side can move");

    // a fresh result follows an input transaction that passed the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result appeared without a matching input transaction");

endmodule

bind conditional_force_effect_core cfe_checker u_cfe_checker (.*);
